/* sv/hhp_pkg.sv */
// Shared types, character codes and helpers for the HTTP Host header parser.
// No dependencies; used by hhp_core and http_host_header_parser.
package hhp_pkg;

    localparam int unsigned HOST_MAX_DEF  = 256;
    localparam logic [15:0] PORT_RST      = 16'd80;
    localparam logic [15:0] PORT_SAT      = 16'hFFFF;

    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_RBRACK = 8'h5D;
    localparam logic [7:0] CHAR_LOW_H  = 8'h68;
    localparam logic [7:0] CHAR_LOW_O  = 8'h6F;
    localparam logic [7:0] CHAR_LOW_S  = 8'h73;
    localparam logic [7:0] CHAR_LOW_T  = 8'h74;
    localparam logic [7:0] CASE_BIT    = 8'h20;

    // Dense state numbers as seen on the result port
    localparam logic [3:0] CODE_START    = 4'd0;
    localparam logic [3:0] CODE_H        = 4'd1;
    localparam logic [3:0] CODE_HO       = 4'd2;
    localparam logic [3:0] CODE_HOS      = 4'd3;
    localparam logic [3:0] CODE_HOST     = 4'd4;
    localparam logic [3:0] CODE_COLON    = 4'd5;
    localparam logic [3:0] CODE_V6       = 4'd6;
    localparam logic [3:0] CODE_V6_END   = 4'd7;
    localparam logic [3:0] CODE_NAME     = 4'd8;
    localparam logic [3:0] CODE_PORT     = 4'd9;
    localparam logic [3:0] CODE_OTHER    = 4'd10;
    localparam logic [3:0] CODE_CR       = 4'd11;
    localparam logic [3:0] CODE_WS       = 4'd12;
    localparam logic [3:0] CODE_FINISH   = 4'd13;
    localparam logic [3:0] CODE_ERROR    = 4'd14;

    typedef enum logic [14:0] {
        ST_START   = 15'h0001,
        ST_H       = 15'h0002,
        ST_HO      = 15'h0004,
        ST_HOS     = 15'h0008,
        ST_HOST    = 15'h0010,
        ST_COLON   = 15'h0020,
        ST_V6      = 15'h0040,
        ST_V6_END  = 15'h0080,
        ST_NAME    = 15'h0100,
        ST_PORT    = 15'h0200,
        ST_OTHER   = 15'h0400,
        ST_CR      = 15'h0800,
        ST_WS      = 15'h1000,
        ST_FINISH  = 15'h2000,
        ST_ERROR   = 15'h4000
    } state_t;

    // Fixed-width part of one result beat
    typedef struct packed {
        logic       keep_going;
        logic       found_host;
        logic [3:0] parse_state;
        logic [15:0] port_value;
        logic       host_byte_valid;
        logic [7:0] host_byte;
        logic       host_end;
    } result_t;

    function automatic logic [3:0] state_code(input state_t st);
        logic [3:0] code;
        unique case (st)
            ST_START:  code = CODE_START;
            ST_H:      code = CODE_H;
            ST_HO:     code = CODE_HO;
            ST_HOS:    code = CODE_HOS;
            ST_HOST:   code = CODE_HOST;
            ST_COLON:  code = CODE_COLON;
            ST_V6:     code = CODE_V6;
            ST_V6_END: code = CODE_V6_END;
            ST_NAME:   code = CODE_NAME;
            ST_PORT:   code = CODE_PORT;
            ST_OTHER:  code = CODE_OTHER;
            ST_CR:     code = CODE_CR;
            ST_WS:     code = CODE_WS;
            ST_FINISH: code = CODE_FINISH;
            default:   code = CODE_ERROR;
        endcase
        return code;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_TAB) || (c == CHAR_SPACE);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ? (c | CASE_BIT) : c;
    endfunction

endpackage

/* sv/hhp_core.sv */
// Parser state, port accumulator and host counter with the per-beat step logic.
// Depends on hhp_pkg.
module hhp_core #(
    parameter int unsigned HostMax = hhp_pkg::HOST_MAX_DEF,
    localparam int unsigned HW     = $clog2(HostMax + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic [7:0]       step_byte,
    input  logic             cfg_wr_en,
    input  logic [15:0]      cfg_wr_data,
    output hhp_pkg::result_t res,
    output logic [HW-1:0]    host_len
);

    hhp_pkg::state_t state_reg, state_next;
    logic [15:0]   port_reg, port_next;
    logic          port_taken_reg, port_taken_next;
    logic [HW-1:0] count_reg, count_next;
    logic          found_reg, found_next;

    logic        keep, app, term, clr_port, digit_upd, set_found;
    logic [7:0]  ab, lc;
    logic [19:0] port_x10;
    logic [15:0] port_sat;

    // port*10 + digit; max 655359 fits in 20 bits
    assign port_x10 = {1'b0, port_reg, 3'b000} + {3'b000, port_reg, 1'b0}
                      + {16'd0, 4'(step_byte - hhp_pkg::CHAR_ZERO)};
    assign port_sat = (port_x10[19:16] != 4'd0) ? hhp_pkg::PORT_SAT : port_x10[15:0];

    always_comb begin
        lc         = hhp_pkg::to_lower(step_byte);
        state_next = state_reg;
        keep       = 1'b1;
        app        = 1'b0;
        term       = 1'b0;
        ab         = 8'd0;
        clr_port   = 1'b0;
        digit_upd  = 1'b0;
        set_found  = 1'b0;
        unique case (state_reg)
            hhp_pkg::ST_START: state_next = (lc == hhp_pkg::CHAR_LOW_H)
                                            ? hhp_pkg::ST_H : hhp_pkg::ST_OTHER;
            hhp_pkg::ST_H:     state_next = (lc == hhp_pkg::CHAR_LOW_O)
                                            ? hhp_pkg::ST_HO : hhp_pkg::ST_OTHER;
            hhp_pkg::ST_HO:    state_next = (lc == hhp_pkg::CHAR_LOW_S)
                                            ? hhp_pkg::ST_HOS : hhp_pkg::ST_OTHER;
            hhp_pkg::ST_HOS:   state_next = (lc == hhp_pkg::CHAR_LOW_T)
                                            ? hhp_pkg::ST_HOST : hhp_pkg::ST_OTHER;
            hhp_pkg::ST_HOST:  state_next = (step_byte == hhp_pkg::CHAR_COLON)
                                            ? hhp_pkg::ST_COLON : hhp_pkg::ST_OTHER;
            hhp_pkg::ST_COLON: begin
                if (step_byte == hhp_pkg::CHAR_LBRACK) begin
                    state_next = hhp_pkg::ST_V6;
                end else if (!hhp_pkg::is_ws(step_byte)) begin
                    state_next = hhp_pkg::ST_NAME;
                    app        = 1'b1;
                    ab         = step_byte;
                end
            end
            hhp_pkg::ST_V6: begin
                app = 1'b1;
                if (step_byte == hhp_pkg::CHAR_RBRACK) begin
                    state_next = hhp_pkg::ST_V6_END;
                    term       = 1'b1;
                end else begin
                    ab = step_byte;
                end
            end
            hhp_pkg::ST_V6_END: begin
                priority if (step_byte == hhp_pkg::CHAR_CR) begin
                    state_next = hhp_pkg::ST_FINISH;
                end else if (step_byte == hhp_pkg::CHAR_COLON) begin
                    state_next = hhp_pkg::ST_PORT;
                    clr_port   = 1'b1;
                end else if (hhp_pkg::is_ws(step_byte)) begin
                    state_next = hhp_pkg::ST_WS;
                end else begin
                    state_next = hhp_pkg::ST_ERROR;
                end
            end
            hhp_pkg::ST_NAME: begin
                app = 1'b1;
                priority if (step_byte == hhp_pkg::CHAR_CR) begin
                    state_next = hhp_pkg::ST_FINISH;
                    term       = 1'b1;
                end else if (step_byte == hhp_pkg::CHAR_COLON) begin
                    state_next = hhp_pkg::ST_PORT;
                    term       = 1'b1;
                    clr_port   = 1'b1;
                end else if (hhp_pkg::is_ws(step_byte)) begin
                    state_next = hhp_pkg::ST_WS;
                    term       = 1'b1;
                end else begin
                    ab = step_byte;
                end
            end
            hhp_pkg::ST_PORT: begin
                priority if (step_byte == hhp_pkg::CHAR_CR) begin
                    state_next = hhp_pkg::ST_FINISH;
                end else if ((step_byte < hhp_pkg::CHAR_ZERO) ||
                             (step_byte > hhp_pkg::CHAR_NINE)) begin
                    state_next = hhp_pkg::ST_ERROR;
                end else begin
                    digit_upd = 1'b1;
                end
            end
            hhp_pkg::ST_OTHER: state_next = (step_byte == hhp_pkg::CHAR_CR)
                                            ? hhp_pkg::ST_CR : hhp_pkg::ST_OTHER;
            hhp_pkg::ST_CR:    state_next = (step_byte == hhp_pkg::CHAR_LF)
                                            ? hhp_pkg::ST_START : hhp_pkg::ST_OTHER;
            hhp_pkg::ST_WS: begin
                priority if (step_byte == hhp_pkg::CHAR_CR) begin
                    state_next = hhp_pkg::ST_FINISH;
                end else if (!hhp_pkg::is_ws(step_byte)) begin
                    state_next = hhp_pkg::ST_ERROR;
                end
            end
            hhp_pkg::ST_FINISH: begin
                keep = 1'b0;
                if (step_byte == hhp_pkg::CHAR_LF) begin
                    set_found = 1'b1;
                end else begin
                    state_next = hhp_pkg::ST_ERROR;
                end
            end
            default: begin
                keep       = 1'b0;
                state_next = hhp_pkg::ST_ERROR;
            end
        endcase

        // host buffer full: drop the append and fail
        if (app && (count_reg == HW'(HostMax))) begin
            app        = 1'b0;
            term       = 1'b0;
            ab         = 8'd0;
            state_next = hhp_pkg::ST_ERROR;
        end

        count_next      = count_reg + HW'(app);
        found_next      = found_reg | set_found;
        port_taken_next = port_taken_reg | clr_port;
        priority if (clr_port) begin
            port_next = 16'd0;
        end else if (digit_upd) begin
            port_next = port_sat;
        end else begin
            port_next = port_reg;
        end
    end

    // default_port only matters as a reload value until a colon claims the port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= hhp_pkg::ST_START;
            port_reg       <= hhp_pkg::PORT_RST;
            port_taken_reg <= 1'b0;
            count_reg      <= '0;
            found_reg      <= 1'b0;
        end else if (step_en) begin
            state_reg      <= state_next;
            port_reg       <= port_next;
            port_taken_reg <= port_taken_next;
            count_reg      <= count_next;
            found_reg      <= found_next;
        end else if (cfg_wr_en && !port_taken_reg) begin
            port_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        res.keep_going      = keep;
        res.found_host      = found_next;
        res.parse_state     = hhp_pkg::state_code(state_next);
        res.port_value      = port_next;
        res.host_byte_valid = app;
        res.host_byte       = ab;
        res.host_end        = term;
    end

    assign host_len = count_next;

endmodule

/* sv/http_host_header_parser.sv */
// HTTP Host header parser: one header byte in, one result beat out.
// A byte accepted on s_ gives its result on m_* once the step has written the result register.
// Throughput: one byte per cycle while m_ready holds; input register -> step logic -> result register.
// Ready on s_ passes through combinationally from m_ready when both registers hold beats.
// Reset (aresetn low, synchronous): parser at line start, port 80, host count 0,
// found flag clear, both registers empty. Depends on hhp_pkg and hhp_core.
module http_host_header_parser #(
    parameter int unsigned HostMax = hhp_pkg::HOST_MAX_DEF,
    localparam int unsigned HW     = $clog2(HostMax + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    // default_port register write
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data,
    // header byte stream
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_header_byte,
    // result stream
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_keep_going,
    output logic          m_found_host,
    output logic [3:0]    m_parse_state,
    output logic [15:0]   m_port_value,
    output logic          m_host_byte_valid,
    output logic [7:0]    m_host_byte,
    output logic          m_host_end,
    output logic [HW-1:0] m_host_length
);

    // Input register: holds one accepted beat until the step logic takes it
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Result register
    logic             out_valid_reg;
    hhp_pkg::result_t out_res_reg;
    logic [HW-1:0]    out_len_reg;

    hhp_pkg::result_t step_res;
    logic [HW-1:0]    step_len;
    logic             advance;

    // The step fires when a byte is staged and the result slot is free or draining.
    // Parser state only moves on a step, so each byte is processed exactly once.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_header_byte;
        end
    end

    hhp_core #(
        .HostMax (HostMax)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .step_byte   (in_byte_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res         (step_res),
        .host_len    (step_len)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
            out_len_reg <= step_len;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_keep_going      = out_res_reg.keep_going;
    assign m_found_host      = out_res_reg.found_host;
    assign m_parse_state     = out_res_reg.parse_state;
    assign m_port_value      = out_res_reg.port_value;
    assign m_host_byte_valid = out_res_reg.host_byte_valid;
    assign m_host_byte       = out_res_reg.host_byte;
    assign m_host_end        = out_res_reg.host_end;
    assign m_host_length     = out_len_reg;

endmodule

/* tb/sv/http_host_header_parser_test.sv */
// Self-checking bench for http_host_header_parser: feeds header bytes over the s_ channel,
// predicts every m_ beat with an in-bench model of the parser and compares them in order.
// Depends on hhp_pkg and the http_host_header_parser RTL.
module http_host_header_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hhp_pkg::*;

    localparam int unsigned HOST_MAX   = HOST_MAX_DEF;
    localparam int unsigned LEN_W      = $clog2(HOST_MAX + 1);
    localparam int CLK_HALF            = 5;
    localparam int RESET_CYCLES        = 5;
    // two register stages inside, a few spare cycles on top
    localparam int SETTLE_CYCLES       = 4;
    localparam int QUIET_LIMIT         = 2000;
    localparam int REPORT_LIMIT        = 10;
    localparam logic [31:0] HOST_WORD  = {CHAR_LOW_H, CHAR_LOW_O, CHAR_LOW_S, CHAR_LOW_T};

    // Only one host line can be parsed per reset, so its shape is picked per seed
    typedef enum int {HOST_IPV6, HOST_NAME, HOST_CR_FIRST, HOST_TOO_LONG} host_form_e;
    typedef enum int {END_PORT, END_BLANKS, END_BARE_CR, END_BAD_PORT} line_end_e;

    typedef struct packed {
        logic             keep_going;
        logic             found_host;
        logic [3:0]       parse_state;
        logic [15:0]      port_value;
        logic             host_byte_valid;
        logic [7:0]       host_byte;
        logic             host_end;
        logic [LEN_W-1:0] host_length;
    } parser_beat_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [15:0]      cfg_wr_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_header_byte = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             m_keep_going;
    logic             m_found_host;
    logic [3:0]       m_parse_state;
    logic [15:0]      m_port_value;
    logic             m_host_byte_valid;
    logic [7:0]       m_host_byte;
    logic             m_host_end;
    logic [LEN_W-1:0] m_host_length;

    // Parser model state, mirrors the block after reset
    logic [3:0]       hdr_state = CODE_START;
    logic [15:0]      port_now = PORT_RST;
    logic [LEN_W-1:0] host_len = '0;
    logic             host_seen = 1'b0;
    logic             port_taken = 1'b0;

    parser_beat_t parse_results_due[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    http_host_header_parser dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_header_byte     (s_header_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_keep_going      (m_keep_going),
        .m_found_host      (m_found_host),
        .m_parse_state     (m_parse_state),
        .m_port_value      (m_port_value),
        .m_host_byte_valid (m_host_byte_valid),
        .m_host_byte       (m_host_byte),
        .m_host_end        (m_host_end),
        .m_host_length     (m_host_length)
    );

    always #CLK_HALF aclk = ~aclk;

    // ---------------------------------------------------------------------
    // Parser model
    // ---------------------------------------------------------------------

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? (c ^ CASE_BIT) : c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB;
    endfunction

    // Advance the model by one header byte and queue the beat it must produce
    function automatic void parser_step(input logic [7:0] c);
        parser_beat_t beat;
        logic [3:0]   nxt;
        logic         keep;
        logic         app;
        logic         term;
        logic [7:0]   hb;
        logic [19:0]  scaled;
        nxt  = hdr_state;
        keep = 1'b1;
        app  = 1'b0;
        term = 1'b0;
        hb   = '0;
        case (hdr_state)
            CODE_START: nxt = (fold_case(c) == CHAR_LOW_H) ? CODE_H : CODE_OTHER;
            CODE_H:     nxt = (fold_case(c) == CHAR_LOW_O) ? CODE_HO : CODE_OTHER;
            CODE_HO:    nxt = (fold_case(c) == CHAR_LOW_S) ? CODE_HOS : CODE_OTHER;
            CODE_HOS:   nxt = (fold_case(c) == CHAR_LOW_T) ? CODE_HOST : CODE_OTHER;
            CODE_HOST:  nxt = (c == CHAR_COLON) ? CODE_COLON : CODE_OTHER;
            CODE_COLON: begin
                // blanks are skipped; anything else but '[' opens a name, CR included
                if (c == CHAR_LBRACK) begin
                    nxt = CODE_V6;
                end else if (!is_blank(c)) begin
                    nxt = CODE_NAME;
                    app = 1'b1;
                    hb  = c;
                end
            end
            CODE_V6: begin
                app = 1'b1;
                if (c == CHAR_RBRACK) begin
                    nxt  = CODE_V6_END;
                    term = 1'b1;
                end else begin
                    hb = c;
                end
            end
            CODE_V6_END: begin
                if (c == CHAR_CR) begin
                    nxt = CODE_FINISH;
                end else if (c == CHAR_COLON) begin
                    nxt        = CODE_PORT;
                    port_now   = '0;
                    port_taken = 1'b1;
                end else if (is_blank(c)) begin
                    nxt = CODE_WS;
                end else begin
                    nxt = CODE_ERROR;
                end
            end
            CODE_NAME: begin
                app = 1'b1;
                if (c == CHAR_CR) begin
                    nxt  = CODE_FINISH;
                    term = 1'b1;
                end else if (c == CHAR_COLON) begin
                    nxt        = CODE_PORT;
                    term       = 1'b1;
                    port_now   = '0;
                    port_taken = 1'b1;
                end else if (is_blank(c)) begin
                    nxt  = CODE_WS;
                    term = 1'b1;
                end else begin
                    hb = c;
                end
            end
            CODE_PORT: begin
                if (c == CHAR_CR) begin
                    nxt = CODE_FINISH;
                end else if (c < CHAR_ZERO || c > CHAR_NINE) begin
                    nxt = CODE_ERROR;
                end else begin
                    scaled   = 20'(port_now) * 20'd10 + 20'(c - CHAR_ZERO);
                    port_now = (scaled > 20'(PORT_SAT)) ? PORT_SAT : scaled[15:0];
                end
            end
            CODE_OTHER: nxt = (c == CHAR_CR) ? CODE_CR : CODE_OTHER;
            CODE_CR:    nxt = (c == CHAR_LF) ? CODE_START : CODE_OTHER;
            CODE_WS: begin
                if (c == CHAR_CR) begin
                    nxt = CODE_FINISH;
                end else if (!is_blank(c)) begin
                    nxt = CODE_ERROR;
                end
            end
            CODE_FINISH: begin
                keep = 1'b0;
                if (c == CHAR_LF) begin
                    host_seen = 1'b1;
                end else begin
                    nxt = CODE_ERROR;
                end
            end
            default: begin
                keep = 1'b0;
                nxt  = CODE_ERROR;
            end
        endcase
        // host buffer full: the append is dropped and the parser gives up
        if (app) begin
            if (host_len >= HOST_MAX) begin
                app  = 1'b0;
                term = 1'b0;
                hb   = '0;
                nxt  = CODE_ERROR;
            end else begin
                host_len = host_len + 1'b1;
            end
        end
        hdr_state = nxt;
        beat.keep_going      = keep;
        beat.found_host      = host_seen;
        beat.parse_state     = nxt;
        beat.port_value      = port_now;
        beat.host_byte_valid = app;
        beat.host_byte       = hb;
        beat.host_end        = term;
        beat.host_length     = host_len;
        parse_results_due.push_back(beat);
    endfunction

    // ---------------------------------------------------------------------
    // Result side: random stalls, in-order compare, watchdog
    // ---------------------------------------------------------------------

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic string beat_text(input parser_beat_t bt);
        return $sformatf({"keep=%0b found=%0b state=%0d port=%0d ",
                          "valid=%0b byte=%02h end=%0b len=%0d"},
                         bt.keep_going, bt.found_host, bt.parse_state, bt.port_value,
                         bt.host_byte_valid, bt.host_byte, bt.host_end, bt.host_length);
    endfunction

    task automatic report_mismatch(input string want_text, input parser_beat_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t mismatch: expected %s", $time, want_text);
            $display("%0t           actual   %s", $time, beat_text(got));
        end
    endtask

    always @(posedge aclk) begin : check_beats
        parser_beat_t got;
        parser_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_keep_going, m_found_host, m_parse_state, m_port_value,
                   m_host_byte_valid, m_host_byte, m_host_end, m_host_length};
            if (parse_results_due.size() == 0) begin
                report_mismatch("no beat pending", got);
            end else begin
                want = parse_results_due.pop_front();
                if (got !== want) begin
                    report_mismatch(beat_text(want), got);
                end
            end
        end
    end

    // Any beat on either side resets the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("http_host_header_parser_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Byte source
    // ---------------------------------------------------------------------

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // One beat on s_: optional idle gap first, valid then held until ready
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_header_byte <= b;
        do @(posedge aclk); while (!s_ready);
        parser_step(b);
        bytes_sent++;
    endtask

    // Right-aligned byte string, sent most significant byte first
    task automatic send_bytes(input logic [63:0] seq, input int count);
        for (int i = count - 1; i >= 0; i--) send_byte(seq[8*i +: 8]);
    endtask

    // Stop sending and wait for every pending beat, then let the pipe go quiet
    task automatic settle_parser();
        s_valid <= 1'b0;
        while (parse_results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write only while idle; it reloads the port until a colon took it
    task automatic set_default_port(input logic [15:0] value);
        settle_parser();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (!port_taken) port_now = value;
    endtask

    // Letter i of "host" in random case
    function automatic logic [7:0] host_letter(input int i);
        return HOST_WORD[31 - 8*i -: 8] ^ (CASE_BIT & {8{$urandom_range(1) != 0}});
    endfunction

    function automatic logic [7:0] blank_byte();
        return ($urandom_range(1) != 0) ? CHAR_SPACE : CHAR_TAB;
    endfunction

    // Any byte that keeps a name going
    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CHAR_CR || b == CHAR_COLON || is_blank(b));
        return b;
    endfunction

    // Lines that are not a host line: near misses on "host:" plus raw noise.
    // Never lets a colon follow a full "host", so the parser stays in line skipping.
    task automatic skip_lines(input int count);
        int         stop_at;
        int         matched;
        logic [7:0] b;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(5) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    b = 8'($urandom);
                    if (hdr_state == CODE_HOST && b == CHAR_COLON) b = CHAR_CR;
                    send_byte(b);
                end
            end else begin
                matched = $urandom_range(0, 4);
                for (int i = 0; i < matched; i++) send_byte(host_letter(i));
                do b = 8'($urandom);
                while (matched < 4 ? fold_case(b) == HOST_WORD[31 - 8*matched -: 8]
                                   : b == CHAR_COLON);
                send_byte(b);
                // line body; a lone CR is fine, CR LF would end the line early
                repeat ($urandom_range(0, 10)) begin
                    b = 8'($urandom);
                    if (b == CHAR_LF && hdr_state == CODE_CR) b = CHAR_CR;
                    send_byte(b);
                end
            end
            while (hdr_state != CODE_START)
                send_byte(hdr_state == CODE_CR ? CHAR_LF : CHAR_CR);
        end
    endtask

    // Tail of the host line after the host itself
    task automatic finish_host_line();
        logic [7:0] b;
        case (line_end_e'($urandom_range(0, 3)))
            END_PORT: begin
                // up to seven digits, so the port often saturates
                send_byte(CHAR_COLON);
                repeat ($urandom_range(1, 7)) send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
                send_byte(CHAR_CR);
            end
            END_BLANKS: begin
                repeat ($urandom_range(1, 3)) send_byte(blank_byte());
                send_byte(CHAR_CR);
            end
            END_BAD_PORT: begin
                send_byte(CHAR_COLON);
                repeat ($urandom_range(0, 3)) send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
                do b = 8'($urandom); while (b == CHAR_CR || (b >= CHAR_ZERO && b <= CHAR_NINE));
                send_byte(b);
            end
            default: send_byte(CHAR_CR);
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Prefix matching and case folding at the reset port value
    task automatic test_line_prefixes();
        set_idling(0, 0);
        send_bytes({"HoSt", 8'h00, 8'hFF, CHAR_CR, CHAR_LF}, 8);
        send_bytes({"hOs", CHAR_LF, CHAR_CR, CHAR_LF}, 6);
        send_bytes({"HOST", CHAR_CR, CHAR_CR, CHAR_LF}, 7);
        send_bytes({"Ho", CHAR_COLON, CHAR_CR, CHAR_LF}, 5);
        // 'H' with the top bit set must not match
        send_bytes({8'hC8, CHAR_LBRACK, CHAR_CR, CHAR_LF}, 4);
    endtask

    // Skipped lines under each idling pattern, default port moved between them
    task automatic test_skipped_lines();
        set_idling(0, 0);
        set_default_port(16'd0);
        skip_lines(90);
        set_idling(70, 0);
        set_default_port(PORT_SAT);
        skip_lines(90);
        set_idling(0, 70);
        set_default_port(16'($urandom));
        skip_lines(90);
        set_idling(21, 21);
        set_default_port(16'($urandom));
        skip_lines(90);
    endtask

    // The one host line of the run
    task automatic test_host_line();
        host_form_e form;
        int         n;
        int         zero_at;
        logic [7:0] b;
        form = host_form_e'($urandom_range(0, 3));
        for (int i = 0; i < 4; i++) send_byte(host_letter(i));
        send_byte(CHAR_COLON);
        if (form != HOST_CR_FIRST) begin
            repeat ($urandom_range(0, 3)) send_byte(blank_byte());
        end
        case (form)
            HOST_IPV6: begin
                // literal carries a NUL that must not read as the terminator
                send_byte(CHAR_LBRACK);
                n       = $urandom_range(1, 12);
                zero_at = $urandom_range(0, n - 1);
                for (int i = 0; i < n; i++) begin
                    do b = 8'($urandom); while (b == CHAR_RBRACK);
                    send_byte(i == zero_at ? 8'h00 : b);
                end
                send_byte(CHAR_RBRACK);
                finish_host_line();
            end
            HOST_NAME: begin
                repeat ($urandom_range(1, 20)) send_byte(name_byte());
                finish_host_line();
            end
            HOST_CR_FIRST: begin
                send_byte(CHAR_CR);
                repeat ($urandom_range(0, 8)) send_byte(name_byte());
                finish_host_line();
            end
            default: begin
                // one byte past the host buffer
                repeat (HOST_MAX + 1) send_byte(name_byte());
            end
        endcase
    endtask

    // LF after the end, then the parser must fall to error and stay there
    task automatic test_after_host_line();
        logic [7:0] b;
        if (hdr_state == CODE_FINISH) begin
            send_byte(CHAR_LF);
            send_byte(CHAR_LF);
        end
        set_default_port(16'($urandom));
        do b = 8'($urandom); while (b == CHAR_LF);
        send_byte(b);
        repeat (6) send_byte(8'($urandom));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_line_prefixes();
        test_skipped_lines();
        test_host_line();
        test_after_host_line();
        settle_parser();
        if (mismatch_count == 0 && parse_results_due.size() == 0) begin
            $display("http_host_header_parser_test OK");
        end else begin
            $display("http_host_header_parser_test NOT OK");
        end
        $finish;
    end

endmodule
